// ===== src/ixl_pkg.sv =====
// Package for the indexed record list: sizes, codes and transaction types.
`default_nettype none
package ixl_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // width used for position arithmetic: wide enough for the count and the position field
   localparam int AW    = (CNT_W > 5) ? CNT_W : 5;

   typedef enum logic [2:0] {
      CMD_ADD_FRONT = 3'd0,
      CMD_ADD_BACK  = 3'd1,
      CMD_ADD_AT    = 3'd2,
      CMD_RM_FRONT  = 3'd3,
      CMD_RM_BACK   = 3'd4,
      CMD_RM_AT     = 3'd5,
      CMD_CLEAR     = 3'd6,
      CMD_NOP       = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [30:0] id;
      logic [7:0]  score;
   } rec_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  position;
      logic [30:0] student_id;
      logic [7:0]  student_score;
   } req_payload_type;

   typedef struct packed {
      logic        removed_valid;
      logic [30:0] removed_id;
      logic [7:0]  removed_score;
      logic [4:0]  entry_count;
      logic [1:0]  status;
   } rsp_payload_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [IDX_W-1:0] at;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== src/indexed_record_list.sv =====
// Top level of the indexed record list: command decode, cell chain and result register.
`default_nettype none
// Ordered list of up to DEPTH records (31-bit id, 8-bit score) held in a chain of
// cells, one record per cell, with the front of the list in cell 0. Every command
// transaction is taken and yields exactly one result transaction in the next cycle, so a
// new command may follow each cycle while req_stall is low; the rate is set by the single
// shift step of the cell chain. An insert moves every cell above the target one place
// up, a remove moves them one place down, all cells at once. The removed record is
// gathered from the addressed cell through an OR of all cells' read outputs. Adds to
// a full list, removes from an empty list and bad positions leave the list unchanged
// and are reported in the status. The result sits in an output register, so a command
// is still accepted while a result waits, as long as that result is taken in the same
// cycle; req_stall follows a stalled result.
module indexed_record_list (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire ixl_pkg::req_payload_type req_data,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output ixl_pkg::rsp_payload_type      rsp_data
);
   import ixl_pkg::*;

   // handshake state
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic accept;

   // decode
   cmd_type       cmd;
   cell_ctrl_type ctrl;
   logic [AW-1:0] cnt_ext;
   logic [AW-1:0] pos_ext;
   logic [AW-1:0] at_add;
   logic [AW-1:0] at_rm;
   logic          full;
   logic          empty;
   status_type    status;
   rec_type       new_rec;
   rec_type       removed;

   // cell chain wiring
   rec_type cell_data [DEPTH];
   rec_type cell_read [DEPTH];

   // a result may be replaced when it is taken in the same cycle
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cmd     = cmd_type'(req_data.command);
   assign cnt_ext = AW'(count_ff);
   assign pos_ext = AW'(req_data.position);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign new_rec = '{id: req_data.student_id, score: req_data.student_score};

   // target position for adds and removes
   always_comb begin
      case (cmd)
         CMD_ADD_FRONT: at_add = '0;
         CMD_ADD_BACK:  at_add = cnt_ext;
         default:       at_add = pos_ext;
      endcase
      case (cmd)
         CMD_RM_FRONT: at_rm = '0;
         CMD_RM_BACK:  at_rm = cnt_ext - AW'(1);
         default:      at_rm = pos_ext;
      endcase
   end

   // command decoder: control to the cells, status and the next count
   always_comb begin
      ctrl     = '0;
      status   = ST_OK;
      count_in = count_ff;
      unique case (cmd)
         CMD_ADD_FRONT, CMD_ADD_BACK, CMD_ADD_AT: begin
            ctrl.at = at_add[IDX_W-1:0];
            if (full) begin
               status = ST_FULL;
            end else if (at_add > cnt_ext) begin
               status = ST_RANGE;
            end else begin
               ctrl.insert = accept;
               if (accept) count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_RM_FRONT, CMD_RM_BACK, CMD_RM_AT: begin
            ctrl.at = at_rm[IDX_W-1:0];
            if (empty) begin
               status = ST_EMPTY;
            end else if (at_rm >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               ctrl.remove = accept;
               if (accept) count_in = count_ff - CNT_W'(1);
            end
         end
         CMD_CLEAR: begin
            if (accept) count_in = '0;
         end
         default: begin
            // no operation
         end
      endcase
   end

   // chain of cells; cell 0 is the front of the list
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;
      if (k == 0) begin : g_first
         assign left_rec = new_rec;
      end else begin : g_mid_l
         assign left_rec = cell_data[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign right_rec = cell_data[k];
      end else begin : g_mid_r
         assign right_rec = cell_data[k+1];
      end
      ixl_cell u_cell (
         .clock     (clock),
         .idx       (IDX_W'(k)),
         .ctrl      (ctrl),
         .new_rec   (new_rec),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .data_rec  (cell_data[k]),
         .read_rec  (cell_read[k])
      );
   end

   // read bus: at most one cell drives a non-zero record
   always_comb begin
      removed = '0;
      for (int k = 0; k < DEPTH; k++) begin
         removed = removed | cell_read[k];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.removed_valid = ctrl.remove;
         rsp_data_in.removed_id    = removed.id;
         rsp_data_in.removed_score = removed.score;
         rsp_data_in.entry_count   = 5'(count_in);
         rsp_data_in.status        = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/ixl_cell.sv =====
// One slot of the record chain: holds a record, shifts from either neighbour.
`default_nettype none
module ixl_cell (
   input  wire                         clock,
   input  wire [ixl_pkg::IDX_W-1:0]    idx,
   input  wire ixl_pkg::cell_ctrl_type ctrl,
   input  wire ixl_pkg::rec_type       new_rec,
   input  wire ixl_pkg::rec_type       left_rec,
   input  wire ixl_pkg::rec_type       right_rec,
   output ixl_pkg::rec_type            data_rec,
   output ixl_pkg::rec_type            read_rec
);
   import ixl_pkg::*;

   rec_type slot_ff;
   rec_type slot_in;
   logic    hit;
   logic    above;

   assign hit   = (idx == ctrl.at);
   assign above = (idx > ctrl.at);

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.insert) begin
         if (hit)        slot_in = new_rec;
         else if (above) slot_in = left_rec;
      end else if (ctrl.remove) begin
         if (hit || above) slot_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign data_rec = slot_ff;
   // only the addressed cell puts its record on the read bus
   assign read_rec = (ctrl.remove && hit) ? slot_ff : '0;

endmodule
`default_nettype wire

// ===== src/ixl_checker.sv =====
// Port-level checker for the indexed record list, bound to the top level.
`default_nettype none
module ixl_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_stall,
   input wire ixl_pkg::req_payload_type req_data,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input wire ixl_pkg::rsp_payload_type rsp_data
);
   import ixl_pkg::*;

   // a stalled command holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled command changed");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // every accepted command yields a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted command gave no result");

   // removed fields are zero unless a record came out, and then status is ok
   a_removed_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.removed_valid ? (rsp_data.status == ST_OK)
                     : (rsp_data.removed_id == '0 && rsp_data.removed_score == '0)))
      else $error("removed record fields inconsistent");

   // a full status comes with a full count, an empty status with a zero count
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != ST_FULL || rsp_data.entry_count == 5'(DEPTH))
                 && (rsp_data.status != ST_EMPTY || rsp_data.entry_count == '0))
      else $error("status disagrees with count");

endmodule

bind indexed_record_list ixl_checker u_ixl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
